[hw/rtl/rca_pkg.sv]
// Package for the register cache allocator: sizes, item structs, entry read-out
// and store command types, and small index helpers. No dependencies.
package rca_pkg;

	localparam int ENTRIES   = 8;
	localparam int TAG_WIDTH = 12;
	localparam int IDX_W     = $clog2(ENTRIES);

	typedef enum logic [1:0] {
		KIND_ACQUIRE = 2'd0,
		KIND_FREE    = 2'd1,
		KIND_FLUSH   = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic [TAG_WIDTH-1:0] tag;
		logic                 tag_valid;
		logic                 will_write;
		logic [2:0]           exclude_a;
		logic                 exclude_a_valid;
		logic [2:0]           exclude_b;
		logic                 exclude_b_valid;
		logic [2:0]           entry_select;
	} in_item_t;

	typedef struct packed {
		logic [2:0]           entry;
		logic                 hit;
		logic                 writeback_valid;
		logic [2:0]           writeback_entry;
		logic [TAG_WIDTH-1:0] writeback_tag;
		logic                 last;
	} out_item_t;

	// Contents of the entry under the read index.
	typedef struct packed {
		logic [TAG_WIDTH-1:0] tag;
		logic                 present;
		logic                 busy;
		logic                 dirty;
	} entry_rd_t;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_DIRTY   = 2'd1,
		ST_ALLOC   = 2'd2,
		ST_RELEASE = 2'd3
	} store_op_t;

	typedef struct packed {
		store_op_t            op;
		logic [IDX_W-1:0]     idx;
		logic [TAG_WIDTH-1:0] tag;
		logic                 tag_valid;
		logic                 will_write;
	} store_cmd_t;

	// Outcome of the shared compare unit for one entry.
	typedef struct packed {
		logic match;
		logic free;
		logic excl;
		logic wb;
	} cmp_res_t;

	// Round-robin successor of an entry index.
	function automatic logic [IDX_W-1:0] rca_next(input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] r;
		if (i == IDX_W'(ENTRIES - 1)) r = '0;
		else r = i + IDX_W'(1);
		return r;
	endfunction

	// An excluded index at or beyond ENTRIES matches nothing.
	function automatic logic idx_eq(input logic [IDX_W-1:0] i, input logic [2:0] e);
		return 32'(e) == 32'(i);
	endfunction

endpackage

[hw/rtl/rca_store.sv]
// Entry store: tag, present, busy and dirty per entry, one read index and one
// write command a cycle. Depends on rca_pkg.
module rca_store import rca_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] rd_idx,
	output entry_rd_t        rd,
	input  store_cmd_t       cmd
);

	logic [TAG_WIDTH-1:0] tags_q [ENTRIES];
	logic [ENTRIES-1:0]   present_q;
	logic [ENTRIES-1:0]   busy_q;
	logic [ENTRIES-1:0]   dirty_q;

	assign rd.tag     = tags_q[rd_idx];
	assign rd.present = present_q[rd_idx];
	assign rd.busy    = busy_q[rd_idx];
	assign rd.dirty   = dirty_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			busy_q    <= '0;
			dirty_q   <= '0;
		end else begin
			case (cmd.op)
				ST_DIRTY: begin
					if (cmd.will_write) dirty_q[cmd.idx] <= 1'b1;
				end
				ST_ALLOC: begin
					busy_q[cmd.idx]    <= 1'b1;
					dirty_q[cmd.idx]   <= cmd.will_write;
					present_q[cmd.idx] <= cmd.tag_valid;
				end
				ST_RELEASE: begin
					busy_q[cmd.idx]    <= 1'b0;
					dirty_q[cmd.idx]   <= 1'b0;
					present_q[cmd.idx] <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Tags are only looked at behind their present bit.
	always_ff @(posedge clk) begin
		if (cmd.op == ST_ALLOC && cmd.tag_valid) tags_q[cmd.idx] <= cmd.tag;
	end

endmodule

[hw/rtl/rca_cmp.sv]
// Shared compare unit: tag match, free test, exclusion test and writeback test
// for the entry under the read index. Depends on rca_pkg.
module rca_cmp import rca_pkg::*; (
	input  entry_rd_t        rd,
	input  logic [IDX_W-1:0] idx,
	input  in_item_t         item,
	output cmp_res_t         res
);

	assign res.match = item.tag_valid && rd.present && (rd.tag == item.tag);
	assign res.free  = !rd.busy;
	assign res.excl  = (item.exclude_a_valid && idx_eq(idx, item.exclude_a)) ||
	                   (item.exclude_b_valid && idx_eq(idx, item.exclude_b));
	// A scratch entry is never stored back.
	assign res.wb    = rd.busy && rd.dirty && rd.present;

endmodule

[hw/rtl/register_cache_allocator_top.sv]
// Register cache allocator top: sequencer, output register and the entry
// store and compare unit. Depends on rca_pkg, rca_store and rca_cmp.
//
//   channel | direction | payload    | handshake
//   req     | in        | in_item_t  | req_valid / req_stall
//   rsp     | out       | out_item_t | rsp_valid / rsp_stall
//
// Acquire: each entry in turn goes through the compare unit, then up to three
// round-robin steps and an allocate step on a miss; an early hit ends the scan.
// Free gives one result; flush walks all entries in turn, one result each.
// Reset clears all marks and sets the last-used pointer to ENTRIES-1.
// A stalled result holds the sequencer at its next emitting step.
module register_cache_allocator_top import rca_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_RR    = 6'b000100,
		S_ALLOC = 6'b001000,
		S_FREE  = 6'b010000,
		S_FLUSH = 6'b100000
	} state_t;

	state_t           state_q, state_d;
	in_item_t         item_q;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [IDX_W-1:0] cand_q, cand_d;
	logic             free_found_q, free_found_d;
	logic [IDX_W-1:0] free_idx_q, free_idx_d;
	logic [IDX_W-1:0] last_used_q, last_used_d;
	logic             out_valid_q;
	out_item_t        out_q, out_d;
	logic             emit;
	logic             slot_free;
	logic [IDX_W-1:0] rd_idx;
	logic             sel_ok;
	entry_rd_t        rd;
	cmp_res_t         cmp;
	store_cmd_t       cmd;

	assign slot_free = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign sel_ok    = 32'(item_q.entry_select) < ENTRIES;

	always_comb begin
		unique case (state_q)
			S_ALLOC, S_RR: rd_idx = cand_q;
			S_FREE:        rd_idx = IDX_W'(item_q.entry_select);
			default:       rd_idx = idx_q;
		endcase
	end

	rca_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (rd_idx),
		.rd     (rd),
		.cmd    (cmd)
	);

	rca_cmp u_cmp (
		.rd   (rd),
		.idx  (rd_idx),
		.item (item_q),
		.res  (cmp)
	);

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		cand_d       = cand_q;
		free_found_d = free_found_q;
		free_idx_d   = free_idx_q;
		last_used_d  = last_used_q;
		emit         = 1'b0;
		out_d        = '0;
		cmd.op         = ST_NONE;
		cmd.idx        = rd_idx;
		cmd.tag        = item_q.tag;
		cmd.tag_valid  = item_q.tag_valid;
		cmd.will_write = item_q.will_write;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					idx_d        = '0;
					free_found_d = 1'b0;
					unique case (kind_t'(req.kind))
						KIND_ACQUIRE: state_d = S_SCAN;
						KIND_FREE:    state_d = S_FREE;
						KIND_FLUSH:   state_d = S_FLUSH;
						default:      state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				if (cmp.match) begin
					// Lowest matching entry wins; hold until the result slot frees.
					if (slot_free) begin
						emit        = 1'b1;
						out_d.entry = 3'(idx_q);
						out_d.hit   = 1'b1;
						out_d.last  = 1'b1;
						cmd.op      = ST_DIRTY;
						state_d     = S_IDLE;
					end
				end else begin
					if (!free_found_q && cmp.free) begin
						free_found_d = 1'b1;
						free_idx_d   = idx_q;
					end
					if (idx_q == IDX_W'(ENTRIES - 1)) begin
						if (free_found_q) begin
							cand_d  = free_idx_q;
							state_d = S_ALLOC;
						end else if (cmp.free) begin
							cand_d  = idx_q;
							state_d = S_ALLOC;
						end else begin
							cand_d  = rca_next(last_used_q);
							state_d = S_RR;
						end
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			S_RR: begin
				// Skip excluded candidates; at most two steps.
				if (cmp.excl) cand_d = rca_next(cand_q);
				else state_d = S_ALLOC;
			end
			S_ALLOC: begin
				if (slot_free) begin
					emit                  = 1'b1;
					out_d.entry           = 3'(cand_q);
					out_d.writeback_valid = cmp.wb;
					out_d.writeback_entry = cmp.wb ? 3'(cand_q) : 3'd0;
					out_d.writeback_tag   = cmp.wb ? rd.tag : '0;
					out_d.last            = 1'b1;
					cmd.op                = ST_ALLOC;
					last_used_d           = cand_q;
					state_d               = S_IDLE;
				end
			end
			S_FREE: begin
				if (slot_free) begin
					emit        = 1'b1;
					out_d.entry = item_q.entry_select;
					out_d.last  = 1'b1;
					if (sel_ok) begin
						out_d.writeback_valid = cmp.wb;
						out_d.writeback_entry = cmp.wb ? item_q.entry_select : 3'd0;
						out_d.writeback_tag   = cmp.wb ? rd.tag : '0;
						cmd.op                = ST_RELEASE;
					end
					state_d = S_IDLE;
				end
			end
			S_FLUSH: begin
				if (slot_free) begin
					emit                  = 1'b1;
					out_d.entry           = 3'(idx_q);
					out_d.writeback_valid = cmp.wb;
					out_d.writeback_entry = cmp.wb ? 3'(idx_q) : 3'd0;
					out_d.writeback_tag   = cmp.wb ? rd.tag : '0;
					out_d.last            = (idx_q == IDX_W'(ENTRIES - 1));
					cmd.op                = ST_RELEASE;
					if (idx_q == IDX_W'(ENTRIES - 1)) begin
						last_used_d = IDX_W'(ENTRIES - 1);
						state_d     = S_IDLE;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			cand_q       <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			last_used_q  <= IDX_W'(ENTRIES - 1);
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			idx_q        <= idx_d;
			cand_q       <= cand_d;
			free_found_q <= free_found_d;
			free_idx_q   <= free_idx_d;
			last_used_q  <= last_used_d;
			if (slot_free) out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) item_q <= req;
		if (emit) out_q <= out_d;
	end

	a_wb_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.writeback_valid) |-> (out_q.writeback_entry == out_q.entry))
		else $error("writeback entry differs from result entry");

	a_hit_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.hit) |-> (!out_q.writeback_valid && out_q.last))
		else $error("hit result carries writeback or is not last");

	a_alloc_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC && slot_free) |=> (last_used_q == $past(cand_q)))
		else $error("last-used pointer not moved to granted entry");

	a_rr_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RR && !cmp.excl) |=> (state_q == S_ALLOC))
		else $error("round-robin search did not settle");

	a_flush_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH && slot_free && idx_q == IDX_W'(ENTRIES - 1))
		|=> (last_used_q == IDX_W'(ENTRIES - 1) && state_q == S_IDLE))
		else $error("flush did not restore pointer");

endmodule
